// ----- rtl/busdec_pkg.sv -----
package busdec_pkg;

  // Kind of access, settled from the address and direction alone.
  typedef enum logic [3:0] {
    CLS_MEM,
    CLS_BUSCTL,
    CLS_POWER,
    CLS_SPEAKER,
    CLS_CONST_ONE,
    CLS_BANK,
    CLS_CLKCTL,
    CLS_LCD_CTL,
    CLS_LCD_DATA,
    CLS_PERIPH,
    CLS_SYSRAM,
    CLS_CART,
    CLS_ROM,
    CLS_DROP
  } cls_e;

  typedef enum logic [2:0] {
    ROUTE_MEM      = 3'd0,
    ROUTE_HANDLED  = 3'd1,
    ROUTE_LCD_CTL  = 3'd2,
    ROUTE_LCD_DATA = 3'd3,
    ROUTE_PERIPH   = 3'd4,
    ROUTE_DROP     = 3'd5
  } route_e;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    cls_e        cls;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } item_t;

  typedef struct packed {
    route_e      route;
    logic [17:0] maddr;
    logic        mwr;
    logic [7:0]  rval;
    logic [3:0]  pidx;
    logic        pulse;
    logic        spk;
    logic [4:0]  div;
    logic        power;
  } result_t;

endpackage

// ----- rtl/bus_address_decoder_banked_core.sv -----
// Bus access decoder with banked cartridge and ROM windows. Each input word is one CPU bus
// access (read or write) and yields exactly one output word: the route, the 18-bit backing
// address with its write enable, read data for registers and system RAM, the peripheral
// index, a CPU reset pulse when the power latch is cleared, and the speaker, clock divider
// and power latch as they stand after the access. A front stage classifies the address, a
// two-word queue decouples it from the back stage, which owns the control registers and the
// two system RAM chips and registers its result for the output port. One word is accepted
// and delivered per clock unless the output stalls; a word passes the front register, a queue
// slot and the back output register, the system RAM read port setting the last stage. System
// RAM contents are undefined after reset until written, and no clearing pass is run.
module bus_address_decoder_banked_core #(
  parameter int unsigned SYSRAM_CHIP_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,       // cartridge_is_ram
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,     // address[15:0], write_data[23:16]
  input  logic        s_axis_tuser,     // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // memory_address[17:0], memory_write[18], read_value[26:19], peripheral_index[30:27],
  // cpu_reset_pulse[31], speaker_level[32], clock_divider[37:33], power_hold[38], zero[39]
  output logic [39:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser      // route
);

  logic                push_valid, push_ready;
  busdec_pkg::item_t   push_item;
  logic                pop_valid, pop_ready;
  busdec_pkg::item_t   pop_item;
  busdec_pkg::result_t result;

  busdec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_wr_i      (s_axis_tuser),
    .in_addr_i    (s_axis_tdata[15:0]),
    .in_wdata_i   (s_axis_tdata[23:16]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  busdec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  busdec_back #(
    .SYSRAM_CHIP_BYTES (SYSRAM_CHIP_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  assign m_axis_tuser = result.route;
  assign m_axis_tdata = {1'b0, result.power, result.div, result.spk, result.pulse,
                         result.pidx, result.rval, result.mwr, result.maddr};

  // A reset pulse only comes with the latch dropped in the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] |-> !m_axis_tdata[38])
    else $error("cpu reset pulse with power latch still held");

  // Backing-memory writes are only issued on the memory route.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tuser == busdec_pkg::ROUTE_MEM)
    else $error("memory write on a route other than backing memory");

  // Peripheral index is nonzero only on the peripheral route.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30:27] != 4'd0 |-> m_axis_tuser == busdec_pkg::ROUTE_PERIPH)
    else $error("peripheral index outside the peripheral route");

endmodule

// ----- rtl/busdec_front.sv -----
module busdec_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_wr_i,
  input  logic [15:0]        in_addr_i,
  input  logic [7:0]         in_wdata_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output busdec_pkg::item_t  push_item_o
);

  localparam logic [15:0] AddrLowEnd   = 16'h007F;
  localparam logic [15:0] AddrPerBase  = 16'h0100;
  localparam logic [15:0] AddrPerLast  = 16'h010B;
  localparam logic [15:0] AddrBusCtl   = 16'h0110;
  localparam logic [15:0] AddrPower    = 16'h0111;
  localparam logic [15:0] AddrStatA    = 16'h0114;
  localparam logic [15:0] AddrSpeaker  = 16'h0115;
  localparam logic [15:0] AddrStatB    = 16'h0116;
  localparam logic [15:0] AddrBank     = 16'h0119;
  localparam logic [15:0] AddrClkCtl   = 16'h011A;
  localparam logic [15:0] AddrLcdCtl   = 16'h011E;
  localparam logic [15:0] AddrLcdData  = 16'h011F;
  localparam logic [15:0] AddrLowLast  = 16'h0FFF;
  localparam logic [15:0] AddrRamLast  = 16'h4FFF;
  localparam logic [15:0] AddrCartLast = 16'hCFFF;
  localparam logic [15:0] AddrRomLast  = 16'hEFFF;
  localparam logic [15:0] AddrBootBase = 16'hF800;

  busdec_pkg::cls_e  cls;
  busdec_pkg::item_t item_q;
  logic              valid_q, valid_d;
  logic              accept;

  always_comb begin
    if (in_addr_i <= AddrLowEnd) begin
      cls = busdec_pkg::CLS_MEM;
    end else if (in_addr_i == AddrBusCtl) begin
      cls = busdec_pkg::CLS_BUSCTL;
    end else if (in_addr_i == AddrPower && in_wr_i) begin
      cls = busdec_pkg::CLS_POWER;
    end else if (in_addr_i == AddrSpeaker && in_wr_i) begin
      cls = busdec_pkg::CLS_SPEAKER;
    end else if ((in_addr_i == AddrStatA || in_addr_i == AddrStatB) && !in_wr_i) begin
      cls = busdec_pkg::CLS_CONST_ONE;
    end else if (in_addr_i == AddrBank) begin
      cls = busdec_pkg::CLS_BANK;
    end else if (in_addr_i == AddrClkCtl) begin
      cls = busdec_pkg::CLS_CLKCTL;
    end else if (in_addr_i == AddrLcdCtl) begin
      cls = busdec_pkg::CLS_LCD_CTL;
    end else if (in_addr_i == AddrLcdData) begin
      cls = busdec_pkg::CLS_LCD_DATA;
    end else if (in_addr_i >= AddrPerBase && in_addr_i <= AddrPerLast) begin
      cls = busdec_pkg::CLS_PERIPH;
    end else if (in_addr_i <= AddrLowLast) begin
      cls = busdec_pkg::CLS_MEM;
    end else if (in_addr_i <= AddrRamLast) begin
      cls = busdec_pkg::CLS_SYSRAM;
    end else if (in_addr_i <= AddrCartLast) begin
      cls = busdec_pkg::CLS_CART;
    end else if (in_addr_i <= AddrRomLast) begin
      cls = in_wr_i ? busdec_pkg::CLS_DROP : busdec_pkg::CLS_ROM;
    end else if (in_addr_i >= AddrBootBase && in_wr_i) begin
      cls = busdec_pkg::CLS_DROP;
    end else begin
      cls = busdec_pkg::CLS_MEM;
    end
  end

  assign in_ready_o   = !valid_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cls   <= cls;
      item_q.wr    <= in_wr_i;
      item_q.addr  <= in_addr_i;
      item_q.wdata <= in_wdata_i;
    end
  end

endmodule

// ----- rtl/busdec_queue.sv -----
module busdec_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  busdec_pkg::item_t  push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output busdec_pkg::item_t  pop_item_o
);

  localparam int unsigned PtrW = $clog2(busdec_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(busdec_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(busdec_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(busdec_pkg::QUEUE_DEPTH - 1);

  busdec_pkg::item_t slot_q [busdec_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != Full;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/busdec_back.sv -----
module busdec_back #(
  parameter int unsigned SYSRAM_CHIP_BYTES = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  busdec_pkg::item_t    pop_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output busdec_pkg::result_t  out_result_o
);

  localparam int unsigned ChipAw   = $clog2(SYSRAM_CHIP_BYTES);
  localparam int unsigned MemDepth = 2 ** (ChipAw + 1);
  localparam logic [ChipAw-1:0] ChipMask = ChipAw'(SYSRAM_CHIP_BYTES - 1);

  localparam logic [15:0] SysramBase  = 16'h1000;
  localparam logic [14:0] WinShort    = 15'h0800;
  localparam logic [14:0] WinLong     = 15'h2000;
  localparam logic [17:0] CartOffset  = 18'h1B000;
  localparam logic [17:0] RomOffset   = 18'h3000;
  localparam logic [7:0]  Unmapped    = 8'hFF;
  localparam logic [7:0]  StatusOne   = 8'h01;

  logic [7:0] sysram_mem [MemDepth];
  logic [7:0] mem_rdata_q;

  logic [7:0] bus_ctl_q, bus_ctl_d;
  logic [3:0] clk_ctl_q, clk_ctl_d;
  logic [3:0] bank_q, bank_d;
  logic       power_q, power_d;
  logic       spk_q, spk_d;
  logic       cart_ram_q;

  busdec_pkg::result_t res;
  busdec_pkg::result_t out_res_q;
  logic                out_valid_q, out_valid_d;
  logic                out_use_mem_q;
  logic                fire;

  logic [15:0]       off_full;
  logic [14:0]       off;
  logic [14:0]       end0, end1, rel1, chip_off;
  logic              in_win0, mapped;
  logic [ChipAw:0]   mem_addr;
  logic              mem_we, mem_re, use_mem;
  logic [17:0]       cart_addr, rom_addr;

  assign cfg_ready_o = 1'b1;
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;

  // Two system RAM windows sit back to back from the base; their lengths
  // come from bus-control bits 3 and 2.
  always_comb begin
    off_full = pop_item_i.addr - SysramBase;
    off      = {1'b0, off_full[13:0]};
    end0     = bus_ctl_q[3] ? WinShort : WinLong;
    end1     = end0 + (bus_ctl_q[2] ? WinShort : WinLong);
    rel1     = off - end0;
    in_win0  = off < end0;
    mapped   = off < end1;
    chip_off = in_win0 ? off : rel1;
    mem_addr = {!in_win0, chip_off[ChipAw-1:0] & ChipMask};
  end

  assign cart_addr = {2'b00, pop_item_i.addr} + CartOffset + {1'b0, bank_q[3:2], 15'd0};
  assign rom_addr  = {2'b00, pop_item_i.addr} + RomOffset + {3'b000, bank_q[1:0], 13'd0};

  always_comb begin
    bus_ctl_d = bus_ctl_q;
    clk_ctl_d = clk_ctl_q;
    bank_d    = bank_q;
    power_d   = power_q;
    spk_d     = spk_q;
    use_mem   = 1'b0;
    mem_we    = 1'b0;
    res       = '0;
    res.route = busdec_pkg::ROUTE_MEM;

    case (pop_item_i.cls)
      busdec_pkg::CLS_MEM: begin
        res.maddr = {2'b00, pop_item_i.addr};
        res.mwr   = pop_item_i.wr;
      end
      busdec_pkg::CLS_BUSCTL: begin
        res.route = busdec_pkg::ROUTE_HANDLED;
        if (pop_item_i.wr) begin
          bus_ctl_d = pop_item_i.wdata;
        end else begin
          res.rval = bus_ctl_q;
        end
      end
      busdec_pkg::CLS_POWER: begin
        res.route = busdec_pkg::ROUTE_HANDLED;
        power_d   = pop_item_i.wdata[0];
        res.pulse = !pop_item_i.wdata[0];
      end
      busdec_pkg::CLS_SPEAKER: begin
        res.route = busdec_pkg::ROUTE_HANDLED;
        spk_d     = pop_item_i.wdata[0];
      end
      busdec_pkg::CLS_CONST_ONE: begin
        res.route = busdec_pkg::ROUTE_HANDLED;
        res.rval  = StatusOne;
      end
      busdec_pkg::CLS_BANK: begin
        if (pop_item_i.wr) begin
          // The bank write is mirrored into backing memory as well.
          bank_d    = pop_item_i.wdata[3:0];
          res.maddr = {2'b00, pop_item_i.addr};
          res.mwr   = 1'b1;
        end else begin
          res.route = busdec_pkg::ROUTE_HANDLED;
          res.rval  = {4'h0, bank_q};
        end
      end
      busdec_pkg::CLS_CLKCTL: begin
        res.route = busdec_pkg::ROUTE_HANDLED;
        if (pop_item_i.wr) begin
          clk_ctl_d = pop_item_i.wdata[3:0];
        end else begin
          res.rval = {4'h0, clk_ctl_q};
        end
      end
      busdec_pkg::CLS_LCD_CTL: begin
        res.route = busdec_pkg::ROUTE_LCD_CTL;
      end
      busdec_pkg::CLS_LCD_DATA: begin
        res.route = busdec_pkg::ROUTE_LCD_DATA;
      end
      busdec_pkg::CLS_PERIPH: begin
        res.route = busdec_pkg::ROUTE_PERIPH;
        res.pidx  = pop_item_i.addr[3:0];
      end
      busdec_pkg::CLS_SYSRAM: begin
        res.route = busdec_pkg::ROUTE_HANDLED;
        if (pop_item_i.wr) begin
          mem_we = mapped;
        end else if (mapped) begin
          use_mem = 1'b1;
        end else begin
          res.rval = Unmapped;
        end
      end
      busdec_pkg::CLS_CART: begin
        res.maddr = cart_addr;
        res.mwr   = pop_item_i.wr && cart_ram_q;
      end
      busdec_pkg::CLS_ROM: begin
        res.maddr = rom_addr;
      end
      busdec_pkg::CLS_DROP: begin
        res.route = busdec_pkg::ROUTE_DROP;
      end
      default: begin
        res.route = busdec_pkg::ROUTE_DROP;
      end
    endcase

    res.spk   = spk_d;
    res.power = power_d;
    res.div   = clk_ctl_d[3] ? {1'b0, ~clk_ctl_d[2:0], 1'b1} : 5'd1;
  end

  assign mem_re = fire && use_mem;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_ctl_q   <= '0;
      clk_ctl_q   <= '0;
      bank_q      <= '0;
      power_q     <= 1'b1;
      spk_q       <= 1'b0;
      cart_ram_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cart_ram_q <= cfg_data_i;
      end
      if (fire) begin
        bus_ctl_q <= bus_ctl_d;
        clk_ctl_q <= clk_ctl_d;
        bank_q    <= bank_d;
        power_q   <= power_d;
        spk_q     <= spk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q     <= res;
      out_use_mem_q <= use_mem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && mem_we) begin
      sysram_mem[mem_addr] <= pop_item_i.wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= sysram_mem[mem_addr];
    end
  end

  always_comb begin
    out_result_o = out_res_q;
    if (out_use_mem_q) begin
      out_result_o.rval = mem_rdata_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
